// ----- hdl/sparse_score_accumulate_topk_top_defines.svh -----
// Assertion macros for the RTL of the score accumulator
`ifndef SPARSE_SCORE_ACCUMULATE_TOPK_TOP_DEFINES_SVH
`define SPARSE_SCORE_ACCUMULATE_TOPK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is active
`define SSAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active
`define SSAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/ssat_pkg.sv -----
// ----------------------------------------------------------------------------
// ssat_pkg
// Types and codes for the sparse score accumulator with top-k selection.
// ----------------------------------------------------------------------------
`default_nettype none

package ssat_pkg;

	// input transaction
	typedef struct packed {
		logic [1:0]         func;
		logic [11:0]        node_id;
		logic signed [31:0] weight_code;
		logic signed [31:0] term_multiplier;
		logic               live_flag;
	} in_t;

	// result transaction
	typedef struct packed {
		logic               result_valid;
		logic [11:0]        result_node;
		logic signed [63:0] result_score;
		logic               result_last;
	} out_t;

	// function codes
	localparam logic [1:0] FUNC_ACC    = 2'd0;
	localparam logic [1:0] FUNC_LIVE   = 2'd1;
	localparam logic [1:0] FUNC_FINISH = 2'd2;
	localparam logic [1:0] FUNC_NONE   = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_TOP_K      = 2'd0;
	localparam logic [1:0] CFG_NODE_COUNT = 2'd1;
	localparam logic [1:0] CFG_QUANT_BITS = 2'd2;

	// weight formats
	localparam logic [1:0] QB_FIXED = 2'd0;
	localparam logic [1:0] QB_CODE16 = 2'd2;

	localparam logic [6:0]  TOP_K_RESET      = 7'd10;
	localparam logic [12:0] NODE_COUNT_RESET = 13'd4096;

	localparam logic signed [63:0] SCORE_MAX = {1'b0, {63{1'b1}}};
	localparam logic signed [63:0] SCORE_MIN = {1'b1, {63{1'b0}}};

endpackage

`default_nettype wire

// ----- hdl/sparse_score_accumulate_topk_top.sv -----
// Accumulate: per posting, read, multiply, add and write back. Liveness: one mark
// write. Finish: a read and an evaluate step per node over all MAX_NODES nodes,
// plus an insertion check and entry shifts for each live nonzero node, then one
// result per cycle while the output is taken. A 64-bit compare and one 33x33
// multiplier are the shared units. After reset a clearing pass zeroes the score
// and liveness memories; no input is accepted during it.
// ----------------------------------------------------------------------------
// sparse_score_accumulate_topk_top
// Sparse score accumulator: per-node saturating score memory, liveness marks,
// and a finish sweep that ranks the best top_k live nodes and clears scores.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sparse_score_accumulate_topk_top_defines.svh"

module sparse_score_accumulate_topk_top
	import ssat_pkg::*;
#(
	parameter int MAX_NODES = 4096,
	parameter int MAX_TOP_K = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire in_t        in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output out_t            out_data,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);

	localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int KW = (MAX_TOP_K > 1) ? $clog2(MAX_TOP_K) : 1;
	localparam logic [AW-1:0] LAST_NODE = AW'(MAX_NODES - 1);
	localparam logic [6:0] K_MAX = 7'(MAX_TOP_K);

	typedef enum logic [10:0] {
		ST_CLR     = 11'b000_0000_0001,
		ST_IDLE    = 11'b000_0000_0010,
		ST_ACC_RD  = 11'b000_0000_0100,
		ST_ACC_MUL = 11'b000_0000_1000,
		ST_ACC_WR  = 11'b000_0001_0000,
		ST_LIVE    = 11'b000_0010_0000,
		ST_SCAN_RD = 11'b000_0100_0000,
		ST_SCAN_EV = 11'b000_1000_0000,
		ST_INS_CHK = 11'b001_0000_0000,
		ST_INS     = 11'b010_0000_0000,
		ST_EMIT    = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration
	logic [6:0]  top_k_q;
	logic [12:0] node_count_q;
	logic [1:0]  quant_bits_q;

	// working registers
	in_t                item_q;
	logic [AW-1:0]      n_q;
	logic [KW-1:0]      i_q;
	logic [KW-1:0]      r_q;
	logic [6:0]         count_q;
	logic signed [63:0] cand_s_q;
	logic [11:0]        cand_n_q;
	logic signed [65:0] prod_q;
	out_t               out_q;
	logic               out_valid_q;

	// memories
	logic signed [63:0] score_mem [MAX_NODES];
	logic               live_mem [MAX_NODES];
	logic signed [63:0] score_rd;
	logic               live_rd;
	logic signed [63:0] best_s [MAX_TOP_K];
	logic [11:0]        best_n [MAX_TOP_K];

	logic [31:0]        node_ext;
	logic [AW-1:0]      item_addr;
	logic               node_in_mem;
	logic [6:0]         k_eff;
	logic [KW-1:0]      k_last;
	logic [KW-1:0]      best_ra;
	logic signed [63:0] best_rs_q;
	logic [11:0]        best_rn_q;
	logic               best_we;
	logic signed [63:0] best_wd_s;
	logic [11:0]        best_wd_n;
	logic               ins_shift;
	logic               cand_gt;
	logic               full;
	logic               cand_ok;
	logic               out_free;
	logic               in_acc;
	logic [AW-1:0]      score_ra;
	logic               score_we;
	logic [AW-1:0]      score_wa;
	logic signed [63:0] score_wd;
	logic signed [63:0] contrib;
	logic signed [64:0] sum;
	logic signed [63:0] acc_new;
	logic signed [32:0] mul_b;
	logic [31:0]        n_ext;

	assign node_ext    = 32'(item_q.node_id);
	assign item_addr   = node_ext[AW-1:0];
	assign node_in_mem = node_ext < 32'(MAX_NODES);
	assign n_ext       = 32'(n_q);
	assign k_eff       = (top_k_q > K_MAX) ? K_MAX : top_k_q;
	assign k_last      = KW'(k_eff - 7'd1);
	assign full        = count_q >= k_eff;
	assign in_ready    = (state_q == ST_IDLE);
	assign in_acc      = in_valid && in_ready;
	assign cfg_ready   = 1'b1;
	assign out_valid   = out_valid_q;
	assign out_data    = out_q;
	assign out_free    = !out_valid_q || out_ready;

	// shared compare against the registered best-list entry
	assign cand_gt   = cand_s_q > best_rs_q;
	assign ins_shift = (i_q != '0) && cand_gt;

	// pick the best-list address needed in the next cycle
	always_comb begin
		case (state_q)
			ST_SCAN_EV: best_ra = cand_ok ? k_last : '0;
			ST_INS_CHK: best_ra = (full && !cand_gt) ? '0 :
				((full ? k_last : KW'(count_q)) - KW'(1));
			ST_INS:     best_ra = ins_shift ? (i_q - KW'(2)) : '0;
			ST_EMIT:    best_ra = out_free ? (r_q + KW'(1)) : r_q;
			default:    best_ra = '0;
		endcase
	end

	// best-list write: shift the entry above down, or drop the candidate in
	assign best_we   = (state_q == ST_INS);
	assign best_wd_s = ins_shift ? best_rs_q : cand_s_q;
	assign best_wd_n = ins_shift ? best_rn_q : cand_n_q;

	// candidate test on the scanned entry
	assign cand_ok = (n_ext < 32'(node_count_q)) && live_rd && (score_rd != 64'sd0) &&
		(k_eff != 7'd0);

	// weight operand per format
	always_comb begin
		case (quant_bits_q)
			QB_FIXED:  mul_b = 33'(item_q.weight_code);
			QB_CODE16: mul_b = $signed({17'd0, item_q.weight_code[15:0]});
			default:   mul_b = $signed({25'd0, item_q.weight_code[7:0]});
		endcase
	end

	// scale to Q32.32 with saturation, then saturating add
	always_comb begin
		if (quant_bits_q == QB_FIXED) begin
			contrib = prod_q[63:0];
		end else if (prod_q[65:47] == {19{prod_q[65]}}) begin
			contrib = {prod_q[47:0], 16'd0};
		end else begin
			contrib = prod_q[65] ? SCORE_MIN : SCORE_MAX;
		end
		sum = {score_rd[63], score_rd} + {contrib[63], contrib};
		if (sum[64] != sum[63]) begin
			acc_new = sum[64] ? SCORE_MIN : SCORE_MAX;
		end else begin
			acc_new = sum[63:0];
		end
	end

	// score memory port control
	always_comb begin
		score_ra = (state_q == ST_SCAN_RD) ? n_q : item_addr;
		score_we = 1'b0;
		score_wa = n_q;
		score_wd = 64'sd0;
		case (state_q)
			ST_CLR:     score_we = 1'b1;
			ST_SCAN_EV: score_we = 1'b1;
			ST_ACC_WR: begin
				score_we = (node_ext < 32'(node_count_q)) && node_in_mem;
				score_wa = item_addr;
				score_wd = acc_new;
			end
			default: score_we = 1'b0;
		endcase
	end

	// score and liveness memories
	always_ff @(posedge clk) begin
		if (score_we) begin
			score_mem[score_wa] <= score_wd;
		end
		score_rd <= score_mem[score_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CLR) begin
			live_mem[n_q] <= 1'b0;
		end else if (state_q == ST_LIVE && node_in_mem) begin
			live_mem[item_addr] <= item_q.live_flag;
		end
		live_rd <= live_mem[score_ra];
	end

	// best list: insert shifts one entry a cycle; registered read passes a
	// same-address write straight through
	always_ff @(posedge clk) begin
		if (best_we) begin
			best_s[i_q] <= best_wd_s;
			best_n[i_q] <= best_wd_n;
		end
		if (best_we && i_q == best_ra) begin
			best_rs_q <= best_wd_s;
			best_rn_q <= best_wd_n;
		end else begin
			best_rs_q <= best_s[best_ra];
			best_rn_q <= best_n[best_ra];
		end
	end

	// multiplier stage and item hold
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q <= in_data;
		end
		if (state_q == ST_ACC_MUL) begin
			prod_q <= 66'(signed'({item_q.term_multiplier[31], item_q.term_multiplier}) * mul_b);
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_k_q      <= TOP_K_RESET;
			node_count_q <= NODE_COUNT_RESET;
			quant_bits_q <= QB_FIXED;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TOP_K:      top_k_q <= cfg_data[6:0];
				CFG_NODE_COUNT: node_count_q <= cfg_data[12:0];
				CFG_QUANT_BITS: quant_bits_q <= cfg_data[1:0];
				default:        top_k_q <= top_k_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			n_q         <= '0;
			i_q         <= '0;
			r_q         <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			cand_s_q    <= '0;
			cand_n_q    <= '0;
		end else begin
			// drop the taken result unless the emitter refills the slot
			if (out_valid_q && out_ready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					n_q <= n_q + AW'(1);
					if (n_q == LAST_NODE) begin
						n_q     <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						case (in_data.func)
							FUNC_ACC:  state_q <= ST_ACC_RD;
							FUNC_LIVE: state_q <= ST_LIVE;
							FUNC_FINISH: begin
								n_q     <= '0;
								count_q <= '0;
								state_q <= ST_SCAN_RD;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_ACC_RD:  state_q <= ST_ACC_MUL;
				ST_ACC_MUL: state_q <= ST_ACC_WR;
				ST_ACC_WR:  state_q <= ST_IDLE;
				ST_LIVE:    state_q <= ST_IDLE;
				ST_SCAN_RD: state_q <= ST_SCAN_EV;
				ST_SCAN_EV: begin
					if (cand_ok) begin
						cand_s_q <= score_rd;
						cand_n_q <= 12'(n_ext);
						state_q  <= ST_INS_CHK;
					end else if (n_q == LAST_NODE) begin
						r_q     <= '0;
						state_q <= ST_EMIT;
					end else begin
						n_q     <= n_q + AW'(1);
						state_q <= ST_SCAN_RD;
					end
				end
				ST_INS_CHK: begin
					if (full && !cand_gt) begin
						if (n_q == LAST_NODE) begin
							r_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							n_q     <= n_q + AW'(1);
							state_q <= ST_SCAN_RD;
						end
					end else begin
						i_q     <= full ? k_last : KW'(count_q);
						state_q <= ST_INS;
					end
				end
				ST_INS: begin
					if (ins_shift) begin
						i_q <= i_q - KW'(1);
					end else begin
						if (!full) begin
							count_q <= count_q + 7'd1;
						end
						if (n_q == LAST_NODE) begin
							r_q     <= '0;
							state_q <= ST_EMIT;
						end else begin
							n_q     <= n_q + AW'(1);
							state_q <= ST_SCAN_RD;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (count_q == 7'd0) begin
							out_q   <= '{1'b0, 12'd0, 64'sd0, 1'b1};
							state_q <= ST_IDLE;
						end else begin
							out_q.result_valid <= 1'b1;
							out_q.result_node  <= best_rn_q;
							out_q.result_score <= best_rs_q;
							out_q.result_last  <= (7'(r_q) + 7'd1 == count_q);
							if (7'(r_q) + 7'd1 == count_q) begin
								state_q <= ST_IDLE;
							end else begin
								r_q <= r_q + KW'(1);
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SSAT_ASSERT_NOW(a_count_le_k, clk, arst_n, (state_q == ST_INS || state_q == ST_INS_CHK), (count_q <= k_eff), "best list overfilled")
	`SSAT_ASSERT_NOW(a_ins_bound, clk, arst_n, (state_q == ST_INS), (7'(i_q) <= count_q), "insert index past list end")
	`SSAT_ASSERT_NEXT(a_item_busy, clk, arst_n, (in_acc && in_data.func != FUNC_NONE), (!in_ready), "item accepted without work")
	`SSAT_ASSERT_NEXT(a_emit_from_scan, clk, arst_n, (state_q == ST_SCAN_EV && !cand_ok && n_q != LAST_NODE), (state_q == ST_SCAN_RD), "scan stalled")

endmodule

`default_nettype wire

// ----- verif/sparse_score_accumulate_topk_top_tb.sv -----
// ----------------------------------------------------------------------------
// sparse_score_accumulate_topk_top_tb
// Drives postings, liveness marks and finish sweeps through the score
// accumulator. A behavioral copy of the score and liveness memories predicts
// each ranked result list, and every result is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_score_accumulate_topk_top_tb;
	import ssat_pkg::*;

	localparam int NODES    = 4096;
	localparam int KMAX     = 64;
	localparam int WDOG_MAX = 1000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	in_t         in_data;
	logic        out_valid;
	logic        out_ready;
	out_t        out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	sparse_score_accumulate_topk_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predicted block state
	logic signed [63:0] node_score [NODES];
	logic               node_live [NODES];
	int unsigned        k_reg;
	int unsigned        ncount_reg;
	logic [1:0]         qbits_reg;

	in_t  pending_items [$];
	out_t ranked_expect [$];
	int   errors;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   wdog;

	// config writes, issued by the sequence only while idle
	logic        cfg_req;
	logic [1:0]  cfg_req_idx;
	logic [15:0] cfg_req_val;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
			logic signed [63:0] b);
		logic signed [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s > 65'sd9223372036854775807)
			return SCORE_MAX;
		if (s < -65'sd9223372036854775808)
			return SCORE_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] posting_gain(logic signed [31:0] mul,
			logic signed [31:0] w);
		logic signed [63:0] p;
		logic signed [63:0] lim;
		lim = 64'sd140737488355327;  // largest product that survives the x65536 scale
		if (qbits_reg == QB_FIXED)
			return 64'(mul) * 64'(w);
		if (qbits_reg == QB_CODE16)
			p = 64'(mul) * $signed({48'd0, w[15:0]});
		else
			p = 64'(mul) * $signed({56'd0, w[7:0]});
		if (p > lim)
			return SCORE_MAX;
		if (p < -lim - 1)
			return SCORE_MIN;
		return p <<< 16;
	endfunction

	// apply one transaction to the predicted state, queue any ranked results
	task automatic predict_item(in_t it);
		logic signed [63:0] bs [KMAX];
		logic [11:0]        bn [KMAX];
		int unsigned        cnt, k, lim, pos, i;
		out_t               r;
		case (it.func)
			FUNC_ACC: begin
				if (it.node_id < ncount_reg)
					node_score[it.node_id] = sat_sum(node_score[it.node_id],
						posting_gain(it.term_multiplier, it.weight_code));
			end
			FUNC_LIVE: node_live[it.node_id] = it.live_flag;
			FUNC_FINISH: begin
				k = (k_reg > KMAX) ? KMAX : k_reg;
				lim = (ncount_reg < NODES) ? ncount_reg : NODES;
				cnt = 0;
				if (k > 0) begin
					for (int n = 0; n < lim; n++) begin
						if (node_live[n] && node_score[n] != 0 &&
								!(cnt >= k && !(node_score[n] > bs[k - 1]))) begin
							pos = 0;
							while (pos < cnt && bs[pos] >= node_score[n])
								pos++;
							i = (cnt < k) ? cnt : k - 1;
							while (i > pos) begin
								bs[i] = bs[i - 1];
								bn[i] = bn[i - 1];
								i--;
							end
							bs[pos] = node_score[n];
							bn[pos] = n[11:0];
							if (cnt < k)
								cnt++;
						end
					end
				end
				for (int n = 0; n < NODES; n++)
					node_score[n] = '0;
				if (cnt == 0) begin
					r = '0;
					r.result_last = 1'b1;
					ranked_expect.push_back(r);
				end
				for (int j = 0; j < cnt; j++) begin
					r.result_valid = 1'b1;
					r.result_node = bn[j];
					r.result_score = bs[j];
					r.result_last = (j + 1 == cnt);
					ranked_expect.push_back(r);
				end
			end
			default: ;
		endcase
	endtask

	// driver: present the next pending posting, hold until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || in_ready) begin
			if (pending_items.size() > 0 &&
					$urandom_range(99, 0) >= send_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// model the accepted transaction at the same edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			predict_item(in_data);
	end

	// config driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cfg_valid <= 1'b0;
			cfg_req = 1'b0;
			case (cfg_index)
				CFG_TOP_K:      k_reg = cfg_data[6:0];
				CFG_NODE_COUNT: ncount_reg = cfg_data[12:0];
				CFG_QUANT_BITS: qbits_reg = cfg_data[1:0];
				default: ;
			endcase
		end else if (cfg_req && !cfg_valid) begin
			cfg_valid <= 1'b1;
			cfg_index <= cfg_req_idx;
			cfg_data <= cfg_req_val;
		end
	end

	// monitor: random back-pressure, compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (ranked_expect.size() == 0) begin
					$error("unexpected result node %0d", out_data.result_node);
					errors++;
				end else begin
					out_t e;
					e = ranked_expect.pop_front();
					if (out_data.result_valid !== e.result_valid) begin
						$error("result_valid exp %0d got %0d", e.result_valid,
							out_data.result_valid);
						errors++;
					end
					if (out_data.result_node !== e.result_node) begin
						$error("result_node exp %0d got %0d", e.result_node,
							out_data.result_node);
						errors++;
					end
					if (out_data.result_score !== e.result_score) begin
						$error("result_score exp %0h got %0h", e.result_score,
							out_data.result_score);
						errors++;
					end
					if (out_data.result_last !== e.result_last) begin
						$error("result_last exp %0d got %0d", e.result_last,
							out_data.result_last);
						errors++;
					end
				end
			end
			out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			wdog <= 0;
		else
			wdog <= wdog + 1;
		if (wdog >= WDOG_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic drain();
		while (pending_items.size() > 0 || in_valid || ranked_expect.size() > 0)
			@(posedge clk);
		// accumulate or liveness work may still be in flight
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_req_idx = idx;
		cfg_req_val = val;
		cfg_req = 1'b1;
		while (cfg_req)
			@(posedge clk);
	endtask

	function automatic in_t make_item(logic [1:0] f, int node,
			logic [31:0] w, logic [31:0] m, logic lv);
		in_t it;
		it.func = f;
		it.node_id = node[11:0];
		it.weight_code = w;
		it.term_multiplier = m;
		it.live_flag = lv;
		return it;
	endfunction

	// well-formed query: mark some nodes live, post weights, finish
	task automatic queue_query(int span, int posts);
		int n;
		for (int i = 0; i < span / 2 + 1; i++)
			pending_items.push_back(make_item(FUNC_LIVE, $urandom_range(span, 0),
				$urandom, $urandom, $urandom_range(9, 0) != 0));
		for (int i = 0; i < posts; i++) begin
			n = ($urandom_range(19, 0) == 0) ? $urandom_range(4095, 0)
				: $urandom_range(span, 0);
			pending_items.push_back(make_item(
				($urandom_range(29, 0) == 0) ? FUNC_NONE : FUNC_ACC, n,
				($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(300000, 0),
				($urandom_range(3, 0) == 0) ? $urandom : $urandom_range(200000, 0),
				1'($urandom)));
		end
		pending_items.push_back(make_item(FUNC_FINISH, $urandom, $urandom,
			$urandom, 1'($urandom)));
	endtask

	initial begin
		int count;
		errors = 0;
		wdog = 0;
		cfg_req = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		k_reg = TOP_K_RESET;
		ncount_reg = NODE_COUNT_RESET;
		qbits_reg = QB_FIXED;
		for (int n = 0; n < NODES; n++) begin
			node_score[n] = '0;
			node_live[n] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty answer, extremes, saturation, ties, unused func
		pending_items.push_back(make_item(FUNC_FINISH, 0, 0, 0, 0));
		pending_items.push_back(make_item(FUNC_LIVE, 0, 0, 0, 1));
		pending_items.push_back(make_item(FUNC_LIVE, 4095, 0, 0, 1));
		pending_items.push_back(make_item(FUNC_LIVE, 5, 0, 0, 1));
		pending_items.push_back(make_item(FUNC_LIVE, 6, 0, 0, 1));
		pending_items.push_back(make_item(FUNC_LIVE, 7, 0, 0, 0));
		pending_items.push_back(make_item(FUNC_ACC, 0, 32'h7fffffff, 32'h7fffffff, 0));
		pending_items.push_back(make_item(FUNC_ACC, 0, 32'h7fffffff, 32'h7fffffff, 0));
		pending_items.push_back(make_item(FUNC_ACC, 4095, 32'h80000000, 32'h7fffffff, 1));
		pending_items.push_back(make_item(FUNC_ACC, 4095, 32'h80000000, 32'h7fffffff, 0));
		pending_items.push_back(make_item(FUNC_ACC, 4095, 32'h80000000, 32'h80000000, 0));
		pending_items.push_back(make_item(FUNC_ACC, 5, 32'h00010000, 32'h00020000, 0));
		pending_items.push_back(make_item(FUNC_ACC, 6, 32'h00020000, 32'h00010000, 0));
		pending_items.push_back(make_item(FUNC_ACC, 7, 32'h00010000, 32'h00010000, 0));
		pending_items.push_back(make_item(FUNC_NONE, 5, 32'hffffffff, 32'hffffffff, 1));
		pending_items.push_back(make_item(FUNC_FINISH, 4095, 32'hffffffff, 32'hffffffff, 1));
		drain();

		// quantized codes, saturating scale, small node_count
		write_reg(CFG_QUANT_BITS, 16'(QB_CODE16));
		write_reg(CFG_NODE_COUNT, 16'd6);
		pending_items.push_back(make_item(FUNC_ACC, 5, 32'hffffffff, 32'h7fffffff, 0));
		pending_items.push_back(make_item(FUNC_ACC, 6, 32'h1234ffff, 32'h80000000, 0));
		pending_items.push_back(make_item(FUNC_ACC, 0, 32'h00000003, 32'h00000005, 0));
		pending_items.push_back(make_item(FUNC_FINISH, 0, 0, 0, 0));
		write_reg(CFG_QUANT_BITS, 16'd3);
		write_reg(CFG_NODE_COUNT, 16'd0);
		write_reg(CFG_TOP_K, 16'd0);
		pending_items.push_back(make_item(FUNC_ACC, 0, 32'hffffffff, 32'h7fffffff, 0));
		pending_items.push_back(make_item(FUNC_FINISH, 0, 0, 0, 0));
		write_reg(CFG_NODE_COUNT, 16'd4096);
		write_reg(CFG_TOP_K, 16'd127);
		pending_items.push_back(make_item(FUNC_ACC, 5, 32'h000000ff, 32'hffff0000, 0));
		pending_items.push_back(make_item(FUNC_FINISH, 0, 0, 0, 0));

		// random queries across settings and idling phases
		count = 0;
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			write_reg(CFG_TOP_K, (ph == 3) ? 16'd64 : (ph == 6) ? 16'd1 :
				16'($urandom_range(70, 0)));
			write_reg(CFG_NODE_COUNT, (ph % 3 == 0) ? 16'd4096 :
				16'($urandom_range(120, 1)));
			write_reg(CFG_QUANT_BITS, 16'($urandom_range(3, 0)));
			queue_query((ph == 3) ? 100 : $urandom_range(30, 3), 10);
			count++;
			// one stray item per phase: random func, node and operand fields
			pending_items.push_back(make_item(2'($urandom), $urandom, $urandom,
				$urandom, 1'($urandom)));
		end
		drain();

		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
